@@ rtl/core/tte_pkg.sv @@
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types, character codes and helpers of the text terminal char engine.
// ----------------------------------------------------------------------------
package tte_pkg;

    // Screen geometry defaults
    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    // Register indexes on the configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_FG = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_BG = 1'd1;

    // Reset colors
    localparam logic [3:0] RESET_FG = 4'd7;
    localparam logic [3:0] RESET_BG = 4'd0;

    // Character codes
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
    localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
    localparam logic [7:0] CHAR_UPPER_X   = 8'h58;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_RETURN    = 8'h0D;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F   = 8'h46;

    // Input transaction
    typedef struct packed {
        logic       mode;
        logic [7:0] byte_value;
        logic       last_of_string;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic       write_cell;
        logic [6:0] cell_x;
        logic [4:0] cell_y;
        logic [7:0] cell_char;
        logic [3:0] cell_fg;
        logic [3:0] cell_bg;
        logic       scroll_up;
        logic [6:0] cursor_x;
        logic [4:0] cursor_y;
    } out_item_t;

    // Map an upper-case hex digit to a color; anything else is black
    function automatic logic [3:0] color_of_digit(input logic [7:0] c);
        logic [7:0] diff;
        diff = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            diff = c - CHAR_ZERO;
        end
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
        begin
            diff = c - CHAR_UPPER_A + 8'd10;
        end
        return diff[3:0];
    endfunction

endpackage

@@ rtl/core/tte_stream_if.sv @@
// ----------------------------------------------------------------------------
// tte_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface tte_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

@@ rtl/core/text_terminal_char_engine_core.sv @@
// ----------------------------------------------------------------------------
// text_terminal_char_engine_core
// Text-mode terminal character engine: parses string escapes, tracks cursor
// and colors, and emits one result (cell write, scroll, cursor) per byte.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Handshake          Payload
//  char_in    in   valid/ready        mode, byte_value, last_of_string
//  cell_out   out  valid/ready        write_cell, cell_x/y, cell_char,
//                                     cell_fg/bg, scroll_up, cursor_x/y
//  cfg_*      in   cfg_we (no ready)  cfg_index 0 default_fg, 1 default_bg
//
//  One byte per cycle while char_in.ready is high: the escape/cursor update
//  is a single combinational pass from the state registers into the result
//  register, or into the skid register while the result register stalls.
//  A two-entry output buffer (result register plus skid register) lets the
//  input accept while a result waits; char_in.ready drops only when both hold.
//  rst_n clears cursor, escape state and valid bits and loads reset colors.
//
module text_terminal_char_engine_core #(
    parameter int COLUMNS = tte_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tte_pkg::ROWS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tte_stream_if.sink                       char_in,
    tte_stream_if.source                     cell_out,
    input  logic                             cfg_we,
    input  logic [tte_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tte_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Cursor widths follow the screen geometry; the cursor row never passes
    // the row above the status row.
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 2);

    // Escape parser states
    localparam logic [1:0] ESC_NORMAL   = 2'd0;
    localparam logic [1:0] ESC_AFTER_BS = 2'd1;
    localparam logic [1:0] ESC_WAIT_FG  = 2'd2;
    localparam logic [1:0] ESC_WAIT_BG  = 2'd3;

    // Architectural state
    logic [1:0]       esc_reg, esc_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [3:0]       fg_reg, fg_next;
    logic [3:0]       bg_reg, bg_next;
    logic [3:0]       default_fg_reg;
    logic [3:0]       default_bg_reg;

    // Output buffer
    logic               out_valid_reg;
    tte_pkg::out_item_t out_data_reg;
    logic               skid_valid_reg;
    tte_pkg::out_item_t skid_data_reg;

    logic               in_fire;
    logic               out_fire;
    tte_pkg::out_item_t result;

    // Decode helpers
    logic [7:0] c;
    logic       last;
    logic       do_put;
    logic       put_write;
    logic       put_scroll;

    assign c    = char_in.payload.byte_value;
    assign last = char_in.payload.last_of_string;

    assign char_in.ready  = !skid_valid_reg;
    assign in_fire        = char_in.valid && char_in.ready;
    assign cell_out.valid   = out_valid_reg;
    assign cell_out.payload = out_data_reg;
    assign out_fire       = out_valid_reg && cell_out.ready;

    // ------------------------------------------------------------------------
    // Escape parsing: decide whether the byte is put and update colors.
    // ------------------------------------------------------------------------
    always_comb
    begin
        esc_next = esc_reg;
        fg_next  = fg_reg;
        bg_next  = bg_reg;
        do_put   = 1'b0;
        if (char_in.payload.mode)
        begin
            do_put = 1'b1;
        end
        else
        begin
            case (esc_reg)
                ESC_NORMAL:
                begin
                    if (c == tte_pkg::CHAR_BACKSLASH && !last)
                    begin
                        esc_next = ESC_AFTER_BS;
                    end
                    else
                    begin
                        do_put = 1'b1;
                    end
                end
                ESC_AFTER_BS:
                begin
                    esc_next = ESC_NORMAL;
                    if (c == tte_pkg::CHAR_LBRACKET || c == tte_pkg::CHAR_RBRACKET)
                    begin
                        // A bracket that ends the string prints literally
                        if (last)
                        begin
                            do_put = 1'b1;
                        end
                        else if (c == tte_pkg::CHAR_LBRACKET)
                        begin
                            esc_next = ESC_WAIT_FG;
                        end
                        else
                        begin
                            esc_next = ESC_WAIT_BG;
                        end
                    end
                    else if (c == tte_pkg::CHAR_UPPER_X)
                    begin
                        fg_next = default_fg_reg;
                        bg_next = default_bg_reg;
                    end
                    else
                    begin
                        do_put = 1'b1;
                    end
                end
                ESC_WAIT_FG:
                begin
                    fg_next  = tte_pkg::color_of_digit(c);
                    esc_next = ESC_NORMAL;
                end
                default:
                begin
                    bg_next  = tte_pkg::color_of_digit(c);
                    esc_next = ESC_NORMAL;
                end
            endcase
        end
        // End of string drops any pending escape, in either mode
        if (last)
        begin
            esc_next = ESC_NORMAL;
        end
    end

    // ------------------------------------------------------------------------
    // Cursor motion and cell write for a put byte.
    // ------------------------------------------------------------------------
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        put_write  = 1'b0;
        put_scroll = 1'b0;
        result     = '0;
        if (do_put)
        begin
            case (c)
                tte_pkg::CHAR_NEWLINE:
                begin
                    col_next = '0;
                    if (row_reg < LAST_ROW)
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        row_next   = LAST_ROW;
                        put_scroll = 1'b1;
                    end
                end
                tte_pkg::CHAR_RETURN:
                begin
                    col_next = '0;
                end
                tte_pkg::CHAR_BACKSPACE:
                begin
                    // Home position: nothing to erase
                    if (col_reg == '0 && row_reg == '0)
                    begin
                        put_write = 1'b0;
                    end
                    else
                    begin
                        put_write = 1'b1;
                        if (col_reg == '0)
                        begin
                            col_next = LAST_COL;
                            row_next = row_reg - ROW_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg - COL_W'(1);
                        end
                    end
                    // Erase with a space at the new cursor
                    result.cell_x    = 7'(col_next);
                    result.cell_y    = 5'(row_next);
                    result.cell_char = tte_pkg::CHAR_SPACE;
                end
                default:
                begin
                    put_write        = 1'b1;
                    result.cell_x    = 7'(col_reg);
                    result.cell_y    = 5'(row_reg);
                    result.cell_char = c;
                    if (col_reg < LAST_COL)
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                    else
                    begin
                        // Wrap acts as a newline
                        col_next = '0;
                        if (row_reg < LAST_ROW)
                        begin
                            row_next = row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            row_next   = LAST_ROW;
                            put_scroll = 1'b1;
                        end
                    end
                end
            endcase
        end
        result.write_cell = put_write;
        result.cell_fg    = fg_reg;
        result.cell_bg    = bg_reg;
        // Cell fields read zero when no cell is written
        if (!put_write)
        begin
            result.cell_x    = '0;
            result.cell_y    = '0;
            result.cell_char = '0;
            result.cell_fg   = '0;
            result.cell_bg   = '0;
        end
        result.scroll_up = put_scroll;
        result.cursor_x  = 7'(col_next);
        result.cursor_y  = 5'(row_next);
    end

    // ------------------------------------------------------------------------
    // State registers: advance only on an accepted transaction.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= ESC_NORMAL;
            col_reg <= '0;
            row_reg <= '0;
            fg_reg  <= tte_pkg::RESET_FG;
            bg_reg  <= tte_pkg::RESET_BG;
        end
        else if (in_fire)
        begin
            esc_reg <= esc_next;
            col_reg <= col_next;
            row_reg <= row_next;
            fg_reg  <= fg_next;
            bg_reg  <= bg_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_fg_reg <= tte_pkg::RESET_FG;
            default_bg_reg <= tte_pkg::RESET_BG;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tte_pkg::REG_DEFAULT_FG: default_fg_reg <= cfg_data;
                tte_pkg::REG_DEFAULT_BG: default_bg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Output buffer: result register fed from the skid register first, then
    // from the current transaction; the skid catches a result when stalled.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_data_reg <= result;
            end
            else
            begin
                out_data_reg <= result;
            end
        end
    end

endmodule

@@ rtl/core/tte_checker.sv @@
// ----------------------------------------------------------------------------
// tte_checker
// Port-level checks of the text terminal char engine, bound to the top level.
// ----------------------------------------------------------------------------
module tte_checker #(
    parameter int COLUMNS = tte_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tte_pkg::ROWS_DEFAULT
) (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input tte_pkg::out_item_t out_payload
);

    localparam logic [4:0] SCROLL_ROW = 5'(ROWS - 2);

    // Hold a stalled result unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed or dropped");

    // Cursor stays inside the text area above the status row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(out_payload.cursor_x) < COLUMNS)
                   && (int'(out_payload.cursor_y) <= ROWS - 2))
    else $error("cursor outside text area");

    // A scroll leaves the cursor at the start of the last text row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.scroll_up |->
            out_payload.cursor_x == 7'd0 && out_payload.cursor_y == SCROLL_ROW)
    else $error("scroll with cursor off the last text row");

    // Cell fields are zero when no cell is written
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_payload.write_cell |->
            out_payload.cell_x == '0 && out_payload.cell_y == '0
            && out_payload.cell_char == '0 && out_payload.cell_fg == '0
            && out_payload.cell_bg == '0)
    else $error("cell fields set without a cell write");

endmodule

bind text_terminal_char_engine_core tte_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tte_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (cell_out.valid),
    .out_ready   (cell_out.ready),
    .out_payload (cell_out.payload)
);

@@ tb/text_terminal_char_engine_core_test.sv @@
// ----------------------------------------------------------------------------
// text_terminal_char_engine_core_test
// Self-checking bench of the text terminal char engine. A walked stimulus
// table covers the escapes, control bytes and cursor corners. Random strings
// follow under several idle/stall mixes and default-color settings. Every
// result transaction is checked field by field against an in-bench terminal
// predictor or, for a few table rows, a hand-typed result.
// ----------------------------------------------------------------------------
module text_terminal_char_engine_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tte_pkg::*;

    localparam int COLUMNS     = COLUMNS_DEFAULT;
    localparam int ROWS        = ROWS_DEFAULT;
    localparam int QUIET_LIMIT = 2000;  // cycles with no transaction at all
    localparam int SETTLE      = 4;     // extra cycles waited after the last result
    localparam int HOLD_OFF    = 200;   // long receiver hold for back-pressure

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_OPEN,
        ESC_FG_DIGIT,
        ESC_BG_DIGIT
    } esc_phase_t;

    // One stimulus row: the byte and, for a few rows, a hand-typed result
    typedef struct {
        in_item_t  item;
        bit        is_typed;
        out_item_t typed_out;
    } char_row_t;

    localparam out_item_t NO_WRITE = '0;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tte_stream_if #(.payload_t(in_item_t))  char_in ();
    tte_stream_if #(.payload_t(out_item_t)) cell_out ();

    text_terminal_char_engine_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_in),
        .cell_out  (cell_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Terminal predictor state
    esc_phase_t esc_phase;
    int         cursor_col;
    int         cursor_row;
    logic [3:0] fg_now;
    logic [3:0] bg_now;
    logic [3:0] restore_fg;
    logic [3:0] restore_bg;

    char_row_t  char_backlog [$];
    out_item_t  pending_cells [$];
    int         mismatch_count;

    // Pacing knobs, percent of cycles
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_request;

    // Directed rows. Hand-typed results sit only where the state is obvious:
    // right after reset, at the origin and on the extreme byte values.
    localparam int DIRECTED_ROWS = 26;
    char_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{1'b1, 8'h41, 1'b0}, 1'b1,
          '{1'b1, 7'd0, 5'd0, 8'h41, 4'd7, 4'd0, 1'b0, 7'd1, 5'd0}},
        '{'{1'b0, CHAR_BACKSPACE, 1'b0}, 1'b1,
          '{1'b1, 7'd0, 5'd0, CHAR_SPACE, 4'd7, 4'd0, 1'b0, 7'd0, 5'd0}},
        '{'{1'b0, CHAR_BACKSPACE, 1'b0}, 1'b1, NO_WRITE},
        '{'{1'b0, 8'h00, 1'b0}, 1'b1,
          '{1'b1, 7'd0, 5'd0, 8'h00, 4'd7, 4'd0, 1'b0, 7'd1, 5'd0}},
        '{'{1'b1, 8'hFF, 1'b1}, 1'b1,
          '{1'b1, 7'd1, 5'd0, 8'hFF, 4'd7, 4'd0, 1'b0, 7'd2, 5'd0}},
        '{'{1'b0, CHAR_BACKSLASH, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_BACKSLASH, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_BACKSLASH, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_LBRACKET, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_UPPER_F, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_BACKSLASH, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_RBRACKET, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_NINE, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_BACKSLASH, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_LBRACKET, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, 8'h61, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_BACKSLASH, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, 8'h71, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_BACKSLASH, 1'b1}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_BACKSLASH, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_LBRACKET, 1'b1}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_RETURN, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_BACKSLASH, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b1, CHAR_NEWLINE, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_UPPER_X, 1'b0}, 1'b0, NO_WRITE},
        '{'{1'b0, CHAR_BACKSPACE, 1'b0}, 1'b0, NO_WRITE}
    };

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Map an upper-case hex digit to a color index; anything else is black
    function automatic logic [3:0] hue_of_digit(logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            return 4'(c - CHAR_ZERO);
        end
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
        begin
            return 4'(c - CHAR_UPPER_A + 8'd10);
        end
        return 4'd0;
    endfunction

    // Drop to column 0 of the next row; at the last text row request a scroll
    function automatic logic next_line();
        cursor_col = 0;
        if (cursor_row < ROWS - 2)
        begin
            cursor_row++;
            return 1'b0;
        end
        cursor_row = ROWS - 2;
        return 1'b1;
    endfunction

    // Fill the cell-write fields at the current cursor in the current colors
    function automatic out_item_t paint(logic [7:0] c);
        out_item_t r;
        r            = '0;
        r.write_cell = 1'b1;
        r.cell_x     = 7'(cursor_col);
        r.cell_y     = 5'(cursor_row);
        r.cell_char  = c;
        r.cell_fg    = fg_now;
        r.cell_bg    = bg_now;
        return r;
    endfunction

    // Put one byte on the screen: controls move the cursor, others print
    function automatic out_item_t render_char(logic [7:0] c);
        out_item_t r;
        r = '0;
        if (c == CHAR_NEWLINE)
        begin
            r.scroll_up = next_line();
        end
        else if (c == CHAR_RETURN)
        begin
            cursor_col = 0;
        end
        else if (c == CHAR_BACKSPACE)
        begin
            // At the origin a backspace does nothing at all
            if (cursor_col != 0 || cursor_row != 0)
            begin
                if (cursor_col == 0)
                begin
                    cursor_col = COLUMNS - 1;
                    cursor_row--;
                end
                else
                begin
                    cursor_col--;
                end
                r = paint(CHAR_SPACE);
            end
        end
        else
        begin
            r = paint(c);
            if (cursor_col < COLUMNS - 1)
            begin
                cursor_col++;
            end
            else
            begin
                r.scroll_up = next_line();
            end
        end
        return r;
    endfunction

    // Advance the terminal by one accepted byte and return its result
    function automatic out_item_t step_terminal(in_item_t it);
        out_item_t  r;
        logic [7:0] c;
        r = '0;
        c = it.byte_value;
        if (it.mode)
        begin
            r = render_char(c);
        end
        else
        begin
            case (esc_phase)
                ESC_IDLE:
                begin
                    // A backslash that ends the string prints literally
                    if (c == CHAR_BACKSLASH && !it.last_of_string)
                    begin
                        esc_phase = ESC_OPEN;
                    end
                    else
                    begin
                        r = render_char(c);
                    end
                end
                ESC_OPEN:
                begin
                    esc_phase = ESC_IDLE;
                    if (c == CHAR_LBRACKET || c == CHAR_RBRACKET)
                    begin
                        if (it.last_of_string)
                        begin
                            r = render_char(c);
                        end
                        else
                        begin
                            esc_phase = (c == CHAR_LBRACKET) ? ESC_FG_DIGIT : ESC_BG_DIGIT;
                        end
                    end
                    else if (c == CHAR_UPPER_X)
                    begin
                        fg_now = restore_fg;
                        bg_now = restore_bg;
                    end
                    else
                    begin
                        r = render_char(c);
                    end
                end
                ESC_FG_DIGIT:
                begin
                    fg_now    = hue_of_digit(c);
                    esc_phase = ESC_IDLE;
                end
                default:
                begin
                    bg_now    = hue_of_digit(c);
                    esc_phase = ESC_IDLE;
                end
            endcase
        end
        // End of string clears any open escape, raw mode included
        if (it.last_of_string)
        begin
            esc_phase = ESC_IDLE;
        end
        r.cursor_x = 7'(cursor_col);
        r.cursor_y = 5'(cursor_row);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    function automatic void queue_byte(ref in_item_t line [$], input logic mode,
                                       input logic [7:0] c);
        in_item_t it;
        it.mode           = mode;
        it.byte_value     = c;
        it.last_of_string = 1'b0;
        line.push_back(it);
    endfunction

    // Mostly a color digit, now and then any byte (lowercase, junk)
    function automatic logic [7:0] pick_digit();
        int v;
        if ($urandom_range(9) == 0)
        begin
            return 8'($urandom_range(255));
        end
        v = $urandom_range(15);
        return (v < 10) ? 8'(CHAR_ZERO + v) : 8'(CHAR_UPPER_A + v - 10);
    endfunction

    // Append random strings (and a little noise) until count bytes are queued
    task automatic queue_random_text(int count);
        in_item_t  line [$];
        char_row_t row;
        int        added;
        int        tokens;
        int        shape;
        int        pick;
        int        k;
        added = 0;
        row.is_typed  = 1'b0;
        row.typed_out = NO_WRITE;
        while (added < count)
        begin
            line.delete();
            shape = $urandom_range(99);
            if (shape < 8)
            begin
                // Noise: one byte with every field at random
                row.item.mode           = 1'($urandom_range(1));
                row.item.byte_value     = 8'($urandom_range(255));
                row.item.last_of_string = 1'($urandom_range(1));
                char_backlog.push_back(row);
                added++;
                continue;
            end
            if (shape < 15)
            begin
                // Long line: forces the wrap at the last column
                tokens = $urandom_range(100, 85);
                for (k = 0; k < tokens; k++)
                begin
                    queue_byte(line, 1'b0, 8'($urandom_range(8'h7E, 8'h20)));
                end
            end
            else if (shape < 21)
            begin
                // Newline burst: walks the cursor down, scrolling at the bottom text row
                tokens = $urandom_range(30, 20);
                for (k = 0; k < tokens; k++)
                begin
                    queue_byte(line, 1'b0, CHAR_NEWLINE);
                end
            end
            else
            begin
                tokens = $urandom_range(12, 1);
                for (k = 0; k < tokens; k++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 45)
                    begin
                        queue_byte(line, 1'b0, 8'($urandom_range(8'h7E, 8'h20)));
                    end
                    else if (pick < 60)
                    begin
                        queue_byte(line, 1'b0, CHAR_BACKSLASH);
                        case ($urandom_range(4))
                            0: queue_byte(line, 1'b0, CHAR_BACKSLASH);
                            1:
                            begin
                                queue_byte(line, 1'b0, CHAR_LBRACKET);
                                queue_byte(line, 1'b0, pick_digit());
                            end
                            2:
                            begin
                                queue_byte(line, 1'b0, CHAR_RBRACKET);
                                queue_byte(line, 1'b0, pick_digit());
                            end
                            3: queue_byte(line, 1'b0, CHAR_UPPER_X);
                            default: queue_byte(line, 1'b0, 8'($urandom_range(255)));
                        endcase
                    end
                    else if (pick < 70)
                    begin
                        queue_byte(line, 1'b0, CHAR_NEWLINE);
                    end
                    else if (pick < 75)
                    begin
                        queue_byte(line, 1'b0, CHAR_RETURN);
                    end
                    else if (pick < 85)
                    begin
                        queue_byte(line, 1'b0, CHAR_BACKSPACE);
                    end
                    else if (pick < 95)
                    begin
                        queue_byte(line, 1'b1, 8'($urandom_range(255)));
                    end
                    else
                    begin
                        queue_byte(line, 1'b0, 8'($urandom_range(255)));
                    end
                end
            end
            // Mark the end of the string; a trailing escape opener stays broken
            line[line.size() - 1].last_of_string = 1'b1;
            foreach (line[k])
            begin
                row.item = line[k];
                char_backlog.push_back(row);
            end
            added += line.size();
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Write both default-color registers; the block is idle here
    task automatic load_defaults(logic [3:0] fg, logic [3:0] bg);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEFAULT_FG;
        cfg_data  <= fg;
        @(posedge clk);
        cfg_index <= REG_DEFAULT_BG;
        cfg_data  <= bg;
        @(posedge clk);
        cfg_we    <= 1'b0;
        restore_fg = fg;
        restore_bg = bg;
    endtask

    // Offer the backlog on char_in; predict each byte at its transaction
    task automatic send_chars();
        char_row_t offered;
        out_item_t predicted;
        bit        busy;
        busy = 1'b0;
        while (char_backlog.size() > 0 || busy)
        begin
            @(posedge clk);
            if (busy && char_in.ready)
            begin
                predicted = step_terminal(offered.item);
                pending_cells.push_back(offered.is_typed ? offered.typed_out : predicted);
                busy = 1'b0;
            end
            if (!busy && char_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                offered          = char_backlog.pop_front();
                char_in.payload <= offered.item;
                char_in.valid   <= 1'b1;
                busy             = 1'b1;
            end
            else if (!busy)
            begin
                char_in.valid <= 1'b0;
            end
        end
    endtask

    // Wait for every expected result, then let the pipeline settle
    task automatic drain();
        while (pending_cells.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare one result transaction against the oldest expectation
    function automatic void check_cell(out_item_t got);
        out_item_t want;
        if (pending_cells.size() == 0)
        begin
            $error("result transaction with nothing expected: %p", got);
            mismatch_count++;
            return;
        end
        want = pending_cells.pop_front();
        compare_field("write_cell", want.write_cell, got.write_cell);
        compare_field("cell_x", want.cell_x, got.cell_x);
        compare_field("cell_y", want.cell_y, got.cell_y);
        compare_field("cell_char", want.cell_char, got.cell_char);
        compare_field("cell_fg", want.cell_fg, got.cell_fg);
        compare_field("cell_bg", want.cell_bg, got.cell_bg);
        compare_field("scroll_up", want.scroll_up, got.scroll_up);
        compare_field("cursor_x", want.cursor_x, got.cursor_x);
        compare_field("cursor_y", want.cursor_y, got.cursor_y);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Receiver: check each result transaction, then pick next ready.
    // A hold request parks ready low for a long stretch so the skid
    // buffer fills and char_in.ready drops while the sender keeps offering.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        cell_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (cell_out.valid && cell_out.ready)
            begin
                check_cell(cell_out.payload);
            end
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                cell_out.ready <= 1'b0;
            end
            else
            begin
                cell_out.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no transaction moves for too long
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((char_in.valid && char_in.ready) || (cell_out.valid && cell_out.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        // Drive every input to a known value and hold reset
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_DEFAULT_FG;
        cfg_data        <= '0;
        char_in.valid   <= 1'b0;
        char_in.payload <= '0;

        esc_phase      = ESC_IDLE;
        cursor_col     = 0;
        cursor_row     = 0;
        fg_now         = RESET_FG;
        bg_now         = RESET_BG;
        restore_fg     = RESET_FG;
        restore_bg     = RESET_BG;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, no idling; bright white / black restore colors
        load_defaults(4'd15, 4'd0);
        foreach (directed_rows[i])
        begin
            char_backlog.push_back(directed_rows[i]);
        end
        send_chars();
        drain();

        // Random strings at full rate
        load_defaults(4'd0, 4'd15);
        queue_random_text(60);
        send_chars();
        drain();

        // Sparse sender
        load_defaults(4'($urandom_range(15)), 4'($urandom_range(15)));
        send_idle_pct  = 87;
        recv_stall_pct = 0;
        queue_random_text(60);
        send_chars();
        drain();

        // Heavily stalling receiver
        load_defaults(4'($urandom_range(15)), 4'($urandom_range(15)));
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        queue_random_text(60);
        send_chars();
        drain();

        // Both sides idle now and then
        load_defaults(RESET_FG, RESET_BG);
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        queue_random_text(60);
        send_chars();
        drain();

        // Back-pressure: long receiver hold against a full-rate sender
        load_defaults(4'd15, 4'd15);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLD_OFF;
        queue_random_text(60);
        send_chars();
        drain();

        if (pending_cells.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_cells.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
